// ===== design/paired_device_table_defines.svh =====
// ---------------------------------------------------------------------------
// Paired device table assertion macros
// Shared assertion forms for the paired device table checks.
// ---------------------------------------------------------------------------
`ifndef PAIRED_DEVICE_TABLE_DEFINES_SVH
`define PAIRED_DEVICE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define PDT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("paired_device_table: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while in reset.
`define PDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("paired_device_table: next-cycle check failed");

`endif

// ===== design/pdt_pkg.sv =====
// ---------------------------------------------------------------------------
// Paired device table package
// Opcodes, level kinds, register indexes, widths and the control structs.
// ---------------------------------------------------------------------------
package pdt_pkg;

  localparam int ADDR_W = 48;
  localparam int LVL_W  = 8;
  localparam int SEL_W  = 8;
  localparam int SLOT_W = 2;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_FIND = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;

  localparam logic [1:0] LVL_MIC   = 2'd0;
  localparam logic [1:0] LVL_ECHO  = 2'd1;
  localparam logic [1:0] LVL_MAGIC = 2'd2;
  localparam logic [1:0] LVL_MUTE  = 2'd3;

  localparam logic [1:0] REG_DEF_MIC   = 2'd0;
  localparam logic [1:0] REG_DEF_ECHO  = 2'd1;
  localparam logic [1:0] REG_DEF_MAGIC = 2'd2;
  localparam logic [1:0] REG_DEF_MUTE  = 2'd3;

  typedef logic [LVL_W-1:0] level_t;

  typedef struct packed {
    level_t mic;
    level_t echo;
    level_t magic;
    level_t mute;
  } levels_t;

  typedef struct packed {
    logic load_req;
    logic idx_inc;
    logic finish;
  } pdt_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       match;
    logic       idx_last;
  } pdt_stat_t;

endpackage

// ===== design/pdt_regs.sv =====
// ---------------------------------------------------------------------------
// Paired device table configuration registers
// APB-style register file holding the default levels for new entries.
// ---------------------------------------------------------------------------
module pdt_regs
  import pdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output levels_t           dflt
);

  levels_t    dflt_r;
  levels_t    dflt_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign dflt    = dflt_r;

  always_comb begin
    dflt_nxt = dflt_r;
    if (wr_en) begin
      case (reg_idx)
        REG_DEF_MIC:   dflt_nxt.mic   = pwdata[LVL_W-1:0];
        REG_DEF_ECHO:  dflt_nxt.echo  = pwdata[LVL_W-1:0];
        REG_DEF_MAGIC: dflt_nxt.magic = pwdata[LVL_W-1:0];
        REG_DEF_MUTE:  dflt_nxt.mute  = pwdata[LVL_W-1:0];
        default:       dflt_nxt = dflt_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEF_MIC:   prdata = CFG_DW'(dflt_r.mic);
      REG_DEF_ECHO:  prdata = CFG_DW'(dflt_r.echo);
      REG_DEF_MAGIC: prdata = CFG_DW'(dflt_r.magic);
      REG_DEF_MUTE:  prdata = CFG_DW'(dflt_r.mute);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r <= '0;
    end else begin
      dflt_r <= dflt_nxt;
    end
  end

endmodule

// ===== design/pdt_ctrl.sv =====
// ---------------------------------------------------------------------------
// Paired device table controller
// Sequences one request at a time: capture, entry walk, result hand-off.
// ---------------------------------------------------------------------------
module pdt_ctrl
  import pdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  pdt_stat_t stat,
  output pdt_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_free;
  logic scan_done;

  assign out_free  = !out_valid_r || !out_stall;
  assign scan_done = (stat.op != OP_FIND) || stat.match || stat.idx_last;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // A finished request waits here until the output register is free.
        if (scan_done) begin
          if (out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/pdt_datapath.sv =====
// ---------------------------------------------------------------------------
// Paired device table datapath
// Entry storage, request capture, walking address comparator, result register.
// ---------------------------------------------------------------------------
module pdt_datapath
  import pdt_pkg::*;
#(
  parameter int ENTRIES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pdt_cmd_t          cmd,
  output pdt_stat_t         stat,
  input  levels_t           dflt,
  input  logic [1:0]        in_op,
  input  logic [ADDR_W-1:0] in_device_address,
  input  logic [SEL_W-1:0]  in_slot_number,
  input  logic [1:0]        in_level_kind,
  input  logic [LVL_W-1:0]  in_level_value,
  output logic              out_hit,
  output logic [SLOT_W-1:0] out_slot,
  output levels_t           out_levels
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
  localparam logic [SEL_W-1:0] SEL_LIMIT = SEL_W'(ENTRIES);

  // Captured request.
  logic [1:0]        req_op_r;
  logic [ADDR_W-1:0] req_addr_r;
  logic [SEL_W-1:0]  req_sel_r;
  logic [1:0]        req_kind_r;
  logic [LVL_W-1:0]  req_val_r;
  logic [IDX_W-1:0]  idx_r;

  // Table storage.
  logic              valid_r   [ENTRIES];
  logic              valid_nxt [ENTRIES];
  logic [ADDR_W-1:0] addr_r    [ENTRIES];
  logic [ADDR_W-1:0] addr_nxt  [ENTRIES];
  levels_t           lvl_r     [ENTRIES];
  levels_t           lvl_nxt   [ENTRIES];

  // Result register.
  logic              out_hit_r;
  logic [SLOT_W-1:0] out_slot_r;
  levels_t           out_lvl_r;

  logic              res_hit;
  logic [SLOT_W-1:0] res_slot;
  levels_t           res_lvl;

  logic              full;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  add_idx;
  logic [SEL_W-1:0]  add_idx_ext;
  logic              sel_ok;
  logic [IDX_W-1:0]  sel_idx;
  logic [SEL_W-1:0]  scan_idx_ext;

  assign stat.op       = req_op_r;
  assign stat.match    = valid_r[idx_r] && (addr_r[idx_r] == req_addr_r);
  assign stat.idx_last = (idx_r == IDX_LAST);

  assign sel_ok       = (req_sel_r < SEL_LIMIT);
  assign sel_idx      = req_sel_r[IDX_W-1:0];
  assign add_idx      = full ? IDX_LAST : free_idx;
  assign add_idx_ext  = SEL_W'(add_idx);
  assign scan_idx_ext = SEL_W'(idx_r);

  // Lowest invalid slot; the loop walks downward so the lowest one wins.
  always_comb begin
    full     = 1'b1;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        full     = 1'b0;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    lvl_nxt   = lvl_r;
    if (cmd.finish) begin
      case (req_op_r)
        OP_ADD: begin
          // A full table drops the oldest entry and shifts the rest down.
          if (full) begin
            for (int i = 0; i < ENTRIES - 1; i++) begin
              valid_nxt[i] = valid_r[i+1];
              addr_nxt[i]  = addr_r[i+1];
              lvl_nxt[i]   = lvl_r[i+1];
            end
          end
          valid_nxt[add_idx] = 1'b1;
          addr_nxt[add_idx]  = req_addr_r;
          lvl_nxt[add_idx]   = dflt;
        end
        OP_SET: begin
          if (sel_ok) begin
            case (req_kind_r)
              LVL_MIC:   lvl_nxt[sel_idx].mic   = req_val_r;
              LVL_ECHO:  lvl_nxt[sel_idx].echo  = req_val_r;
              LVL_MAGIC: lvl_nxt[sel_idx].magic = req_val_r;
              LVL_MUTE:  lvl_nxt[sel_idx].mute  = req_val_r;
              default:   lvl_nxt[sel_idx].mute  = req_val_r;
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_hit  = 1'b0;
    res_slot = '0;
    res_lvl  = '0;
    case (req_op_r)
      OP_ADD: begin
        res_hit  = 1'b1;
        res_slot = add_idx_ext[SLOT_W-1:0];
      end
      OP_FIND: begin
        if (stat.match) begin
          res_hit  = 1'b1;
          res_slot = scan_idx_ext[SLOT_W-1:0];
          res_lvl  = lvl_r[idx_r];
        end
      end
      OP_SET: begin
        if (sel_ok) begin
          res_hit  = 1'b1;
          res_slot = req_sel_r[SLOT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op_r   <= in_op;
      req_addr_r <= in_device_address;
      req_sel_r  <= in_slot_number;
      req_kind_r <= in_level_kind;
      req_val_r  <= in_level_value;
      idx_r      <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    lvl_r  <= lvl_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_hit_r  <= res_hit;
      out_slot_r <= res_slot;
      out_lvl_r  <= res_lvl;
    end
  end

  assign out_hit    = out_hit_r;
  assign out_slot   = out_slot_r;
  assign out_levels = out_lvl_r;

endmodule

// ===== design/paired_device_table.sv =====
// Add, set-level and unused opcodes: the request is captured, then its result is registered.
// Find: one comparator walks one entry per cycle until a match or the last entry is reached.
// One request in flight; a result is registered only once the output register is free, and the
// next request is accepted the cycle after the result is registered.
// Reset (rst_n low, synchronous) marks every entry invalid and clears the default levels.
// ---------------------------------------------------------------------------
// Paired device table
// Small table of paired devices with add, find and per-entry level updates.
// ---------------------------------------------------------------------------
`include "paired_device_table_defines.svh"

module paired_device_table
  import pdt_pkg::*;
#(
  parameter int ENTRIES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [ADDR_W-1:0] in_device_address,
  input  logic [SEL_W-1:0]  in_slot_number,
  input  logic [1:0]        in_level_kind,
  input  logic [LVL_W-1:0]  in_level_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit,
  output logic [SLOT_W-1:0] out_slot,
  output logic [LVL_W-1:0]  out_mic_lvl,
  output logic [LVL_W-1:0]  out_echo_lvl,
  output logic [LVL_W-1:0]  out_magic_lvl,
  output logic [LVL_W-1:0]  out_mute_lvl
);

  levels_t   dflt;
  levels_t   out_levels;
  pdt_cmd_t  cmd;
  pdt_stat_t stat;

  pdt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dflt    (dflt)
  );

  pdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pdt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .dflt              (dflt),
    .in_op             (in_op),
    .in_device_address (in_device_address),
    .in_slot_number    (in_slot_number),
    .in_level_kind     (in_level_kind),
    .in_level_value    (in_level_value),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_levels        (out_levels)
  );

  assign out_mic_lvl   = out_levels.mic;
  assign out_echo_lvl  = out_levels.echo;
  assign out_magic_lvl = out_levels.magic;
  assign out_mute_lvl  = out_levels.mute;

  // An accepted request keeps the input side busy while it is worked on.
  `PDT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // Only a successful find carries levels; every other result has them at zero.
  `PDT_ASSERT_IMPL(a_miss_levels_zero, out_valid && !out_hit, out_levels == '0)
  // A result can only be finished while the controller is working on a request.
  `PDT_ASSERT_IMPL(a_finish_while_busy, cmd.finish, in_stall && !cmd.load_req)

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Paired device table testbench
// Drives add, find, set-level and unused-opcode requests with random idling on both sides,
// predicts every reply from a private copy of the table and compares each
// reply field by field, with default-level writes between phases.
// ---------------------------------------------------------------------------
module testbench
  import pdt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 4;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_REQUESTS = 170;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int POOL_SIZE = 6;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [SEL_W-1:0]  slot_number;
    logic [1:0]        kind;
    level_t            value;
  } request_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    levels_t           levels;
  } reply_t;

  // Private copy of the table; predicts one reply per accepted request.
  class pairing_tracker;
    logic              entry_used[TABLE_DEPTH];
    logic [ADDR_W-1:0] entry_addr[TABLE_DEPTH];
    levels_t           entry_levels[TABLE_DEPTH];
    levels_t           defaults;
    reply_t            expected_replies[$];
    int                errors;

    function new();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        entry_used[i] = 1'b0;
        entry_addr[i] = '0;
        entry_levels[i] = '0;
      end
      defaults = '0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    function void set_default(logic [1:0] idx, level_t value);
      case (idx)
        REG_DEF_MIC:   defaults.mic = value;
        REG_DEF_ECHO:  defaults.echo = value;
        REG_DEF_MAGIC: defaults.magic = value;
        REG_DEF_MUTE:  defaults.mute = value;
        default: ;
      endcase
    endfunction

    function void note_request(request_t r);
      reply_t rep;
      int pos;
      rep = '0;
      pos = -1;
      case (r.op)
        OP_ADD: begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!entry_used[i] && pos < 0) pos = i;
          end
          // A full table drops its oldest entry and appends at the end.
          if (pos < 0) begin
            for (int i = 0; i + 1 < TABLE_DEPTH; i++) begin
              entry_used[i] = entry_used[i+1];
              entry_addr[i] = entry_addr[i+1];
              entry_levels[i] = entry_levels[i+1];
            end
            pos = TABLE_DEPTH - 1;
          end
          entry_used[pos] = 1'b1;
          entry_addr[pos] = r.addr;
          entry_levels[pos] = defaults;
          rep.hit = 1'b1;
          rep.slot = SLOT_W'(pos);
        end
        OP_FIND: begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!rep.hit && entry_used[i] && entry_addr[i] == r.addr) begin
              rep.hit = 1'b1;
              rep.slot = SLOT_W'(i);
              rep.levels = entry_levels[i];
            end
          end
        end
        OP_SET: begin
          // Invalid entries still take the level.
          if (r.slot_number < TABLE_DEPTH) begin
            case (r.kind)
              LVL_MIC:   entry_levels[r.slot_number].mic = r.value;
              LVL_ECHO:  entry_levels[r.slot_number].echo = r.value;
              LVL_MAGIC: entry_levels[r.slot_number].magic = r.value;
              default:   entry_levels[r.slot_number].mute = r.value;
            endcase
            rep.hit = 1'b1;
            rep.slot = r.slot_number[SLOT_W-1:0];
          end
        end
        default: ;
      endcase
      expected_replies.push_back(rep);
    endfunction

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report("reply arrived with no request pending");
        return;
      end
      want = expected_replies.pop_front();
      check_field("hit", 8'(got.hit), 8'(want.hit));
      check_field("slot", 8'(got.slot), 8'(want.slot));
      check_field("mic_lvl", got.levels.mic, want.levels.mic);
      check_field("echo_lvl", got.levels.echo, want.levels.echo);
      check_field("magic_lvl", got.levels.magic, want.levels.magic);
      check_field("mute_lvl", got.levels.mute, want.levels.mute);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_op;
  logic [ADDR_W-1:0] in_device_address;
  logic [SEL_W-1:0]  in_slot_number;
  logic [1:0]        in_level_kind;
  level_t            in_level_value;
  logic              out_valid;
  logic              out_stall;
  logic              out_hit;
  logic [SLOT_W-1:0] out_slot;
  level_t            out_mic_lvl;
  level_t            out_echo_lvl;
  level_t            out_magic_lvl;
  level_t            out_mute_lvl;

  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  logic              long_hold_pending = 1'b0;
  logic [ADDR_W-1:0] addr_pool[POOL_SIZE];
  pairing_tracker    tracker = new();

  paired_device_table #(.ENTRIES(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_device_address(in_device_address),
    .in_slot_number(in_slot_number),
    .in_level_kind(in_level_kind),
    .in_level_value(in_level_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_hit(out_hit),
    .out_slot(out_slot),
    .out_mic_lvl(out_mic_lvl),
    .out_echo_lvl(out_echo_lvl),
    .out_magic_lvl(out_magic_lvl),
    .out_mute_lvl(out_mute_lvl)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_pending) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_reply({out_hit, out_slot,
                           {out_mic_lvl, out_echo_lvl, out_magic_lvl, out_mute_lvl}});
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] random_addr();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[ADDR_W-1:0];
  endfunction

  function automatic request_t make_request(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                            logic [SEL_W-1:0] slot_number,
                                            logic [1:0] kind, level_t value);
    request_t r;
    r.op = op;
    r.addr = addr;
    r.slot_number = slot_number;
    r.kind = kind;
    r.value = value;
    return r;
  endfunction

  // Mostly pooled addresses so finds hit and duplicates occur; some fully random.
  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.op = (pick < 30) ? OP_ADD : (pick < 70) ? OP_FIND : (pick < 95) ? OP_SET : OP_UNUSED;
    r.addr = ($urandom_range(0, 99) < 80) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : random_addr();
    r.slot_number = ($urandom_range(0, 99) < 75) ? SEL_W'($urandom_range(0, TABLE_DEPTH - 1))
                                                 : SEL_W'($urandom_range(0, 255));
    r.kind = 2'($urandom_range(0, 3));
    r.value = level_t'($urandom_range(0, 255));
    return r;
  endfunction

  task refill_pool();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = random_addr();
  endtask

  // Returns just after the posedge at which the request was taken; valid stays
  // high into the next request unless the sender decides to idle.
  task send_request(request_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_op = r.op;
    in_device_address = r.addr;
    in_slot_number = r.slot_number;
    in_level_kind = r.kind;
    in_level_value = r.value;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    tracker.note_request(r);
  endtask

  task stop_sending();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task write_default(logic [1:0] idx, level_t value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {24'($urandom()), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_default(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task write_defaults(levels_t v);
    write_default(REG_DEF_MIC, v.mic);
    write_default(REG_DEF_ECHO, v.echo);
    write_default(REG_DEF_MAGIC, v.magic);
    write_default(REG_DEF_MUTE, v.mute);
  endtask

  // Stops sending, waits for every outstanding reply, reports any that never arrive, then idles.
  task wait_for_replies();
    int waited;
    waited = 0;
    stop_sending();
    while (tracker.expected_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (tracker.expected_replies.size() != 0) begin
      tracker.report("reply never arrived");
      void'(tracker.expected_replies.pop_front());
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task run_random_phase(int count, bit with_long_hold);
    refill_pool();
    for (int n = 0; n < count; n++) begin
      send_request(random_request());
      if (with_long_hold && n == 40) long_hold_pending = 1'b1;
    end
    wait_for_replies();
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_op = OP_ADD;
    in_device_address = '0;
    in_slot_number = '0;
    in_level_kind = LVL_MIC;
    in_level_value = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    write_defaults({8'h5A, 8'hC3, 8'h01, 8'hFE});

    // Directed: empty table, set on invalid entries, out-of-range slots,
    // fill, lowest-slot find, overflow shift, every level kind, unused opcode.
    send_request(make_request(OP_FIND, '0, 8'd0, LVL_MIC, 8'h00));
    send_request(make_request(OP_SET, '1, 8'd0, LVL_MIC, 8'hFF));
    send_request(make_request(OP_SET, '0, 8'd3, LVL_MUTE, 8'h00));
    send_request(make_request(OP_SET, '0, 8'd4, LVL_ECHO, 8'hAA));
    send_request(make_request(OP_SET, '0, 8'd255, LVL_MAGIC, 8'h55));
    send_request(make_request(OP_ADD, '0, 8'd255, LVL_MUTE, 8'hFF));
    send_request(make_request(OP_ADD, '1, 8'd0, LVL_MIC, 8'h00));
    send_request(make_request(OP_ADD, '1, 8'd7, LVL_ECHO, 8'h12));
    send_request(make_request(OP_ADD, 48'h8000_0000_0001, 8'd1, LVL_MAGIC, 8'h34));
    send_request(make_request(OP_FIND, '1, 8'd0, LVL_MIC, 8'h00));
    send_request(make_request(OP_FIND, '0, 8'd0, LVL_MIC, 8'h00));
    send_request(make_request(OP_ADD, 48'hA5A5_5A5A_0F0F, 8'd2, LVL_MUTE, 8'h77));
    send_request(make_request(OP_FIND, '0, 8'd0, LVL_MIC, 8'h00));
    send_request(make_request(OP_FIND, 48'hA5A5_5A5A_0F0F, 8'd0, LVL_MIC, 8'h00));
    send_request(make_request(OP_SET, '0, 8'd0, LVL_MIC, 8'hFF));
    send_request(make_request(OP_SET, '0, 8'd0, LVL_ECHO, 8'h80));
    send_request(make_request(OP_SET, '0, 8'd0, LVL_MAGIC, 8'h7F));
    send_request(make_request(OP_SET, '0, 8'd0, LVL_MUTE, 8'h00));
    send_request(make_request(OP_FIND, '1, 8'd0, LVL_MIC, 8'h00));
    send_request(make_request(OP_UNUSED, '1, 8'd2, LVL_MUTE, 8'hFF));
    send_request(make_request(OP_FIND, 48'h8000_0000_0001, 8'd0, LVL_MIC, 8'h00));
    send_request(make_request(OP_FIND, 48'h0000_0000_0001, 8'd0, LVL_MIC, 8'h00));
    wait_for_replies();

    write_defaults({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_idle_pct = 30;
    recv_idle_pct = 51;
    run_random_phase(PHASE_REQUESTS, 1'b0);

    write_defaults({8'h00, 8'h00, 8'h00, 8'h00});
    send_idle_pct = 51;
    recv_idle_pct = 30;
    run_random_phase(PHASE_REQUESTS, 1'b1);

    write_defaults(levels_t'({$urandom()}));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(PHASE_REQUESTS, 1'b0);

    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
